[sv/sitda_pkg.sv]
`default_nettype none

package sitda_pkg;

    localparam int DefaultValueWidth = 32;

    localparam logic [7:0] ChZero  = 8'd48;
    localparam logic [7:0] ChMinus = 8'd45;

    // BCD digit correction before each doubling
    localparam logic [3:0] DabbleMin = 4'd5;
    localparam logic [3:0] DabbleAdd = 4'd3;
    localparam logic [3:0] DigitMax  = 4'd9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic clear;   // zero the digit
        logic dabble;  // add-3 correction, then shift one bit in
        logic move;    // take the lower neighbor's digit
    } t_cell_ctrl;

endpackage

`default_nettype wire

[sv/sitda_cell.sv]
`default_nettype none

module sitda_cell (
    input  wire logic                  i_clk,
    input  wire sitda_pkg::t_cell_ctrl i_ctrl,
    input  wire logic                  i_bit,
    input  wire logic [3:0]            i_digit,
    output logic                       o_bit,
    output logic [3:0]                 o_digit
);

    logic [3:0] r_digit;
    logic [3:0] w_adj;

    assign w_adj   = (r_digit >= sitda_pkg::DabbleMin) ? r_digit + sitda_pkg::DabbleAdd
                                                      : r_digit;
    assign o_bit   = w_adj[3];
    assign o_digit = r_digit;

    always_ff @(posedge i_clk) begin
        priority if (i_ctrl.clear) begin
            r_digit <= 4'd0;
        end else if (i_ctrl.dabble) begin
            r_digit <= {w_adj[2:0], i_bit};
        end else if (i_ctrl.move) begin
            r_digit <= i_digit;
        end else begin
            r_digit <= r_digit;
        end
    end

endmodule

`default_nettype wire

[sv/sitda_chain.sv]
`default_nettype none

module sitda_chain #(
    parameter int NUM_DIGITS = 10
) (
    input  wire logic                  i_clk,
    input  wire sitda_pkg::t_cell_ctrl i_ctrl,
    input  wire logic                  i_bit,
    output logic [3:0]                 o_top,
    output logic                       o_ovf
);

    logic [NUM_DIGITS:0] c_bit;
    logic [3:0]          c_dig [NUM_DIGITS+1];

    assign c_bit[0] = i_bit;
    assign c_dig[0] = 4'd0;

    // cell 0 is the least significant digit; bits and digits move upward
    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
        sitda_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (i_ctrl),
            .i_bit   (c_bit[g]),
            .i_digit (c_dig[g]),
            .o_bit   (c_bit[g+1]),
            .o_digit (c_dig[g+1])
        );
    end

    assign o_top = c_dig[NUM_DIGITS];
    assign o_ovf = c_bit[NUM_DIGITS];

endmodule

`default_nettype wire

[sv/signed_int_to_decimal_ascii.sv]
// Operation: after a request is accepted, the magnitude is shifted bit-serially through the
//   BCD cell row (ST_CONV) and leading zeros are dropped (ST_SKIP); then one character per
//   cycle while the receiver does not stall, with a minus sign first for a negative value.
// Requests: o_stall is high outside idle, so a new request is taken only after the last
//   character of the previous one is loaded, owing to the bit-serial shift and digit readout.
// Reset: synchronous, active low; clears the control state and the output valid.
`default_nettype none

module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = sitda_pkg::DefaultValueWidth
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [7:0]                         o_ch,
    output logic                               o_last
);

    // decimal digits of 2^(VALUE_WIDTH-1); 1233/4096 approximates log10(2)
    localparam int NumDigits = ((VALUE_WIDTH - 1) * 1233) / 4096 + 1;
    localparam int CntW      = $clog2(VALUE_WIDTH + 1);
    localparam int LeftW     = $clog2(NumDigits + 1);

    sitda_pkg::t_state     r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_mag, n_mag;
    logic                   r_neg, n_neg;
    logic [CntW-1:0]        r_cnt, n_cnt;
    logic [LeftW-1:0]       r_left, n_left;
    logic                   r_ovalid, n_ovalid;
    logic [7:0]             r_ch, n_ch;
    logic                   r_last, n_last;

    sitda_pkg::t_cell_ctrl  w_ctrl;
    logic [3:0]             w_top;
    logic                   w_ovf;
    logic                   w_oload;

    sitda_chain #(
        .NUM_DIGITS (NumDigits)
    ) u_chain (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_bit  (r_mag[VALUE_WIDTH-1]),
        .o_top  (w_top),
        .o_ovf  (w_ovf)
    );

    assign o_stall = (r_state != sitda_pkg::ST_IDLE);
    assign o_valid = r_ovalid;
    assign o_ch    = r_ch;
    assign o_last  = r_last;
    assign w_oload = !r_ovalid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sitda_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_cnt  <= n_cnt;
        r_left <= n_left;
        r_ch   <= n_ch;
        r_last <= n_last;
    end

    always_comb begin
        n_state  = r_state;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_cnt    = r_cnt;
        n_left   = r_left;
        n_ovalid = r_ovalid && i_stall;
        n_ch     = r_ch;
        n_last   = r_last;
        w_ctrl   = '0;

        unique case (r_state)
            sitda_pkg::ST_IDLE: begin
                if (i_valid) begin
                    // unsigned magnitude, so the most negative value converts in full
                    n_mag        = i_value[VALUE_WIDTH-1]
                                 ? VALUE_WIDTH'(~i_value + 1'b1)
                                 : VALUE_WIDTH'(i_value);
                    n_neg        = i_value[VALUE_WIDTH-1];
                    n_cnt        = CntW'(VALUE_WIDTH);
                    n_left       = LeftW'(NumDigits);
                    w_ctrl.clear = 1'b1;
                    n_state      = sitda_pkg::ST_CONV;
                end
            end
            sitda_pkg::ST_CONV: begin
                w_ctrl.dabble = 1'b1;
                n_mag         = r_mag << 1;
                n_cnt         = r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    n_state = sitda_pkg::ST_SKIP;
                end
            end
            sitda_pkg::ST_SKIP: begin
                // drop leading zeros, keep at least one digit
                if (w_top == 4'd0 && r_left != LeftW'(1)) begin
                    w_ctrl.move = 1'b1;
                    n_left      = r_left - 1'b1;
                end else begin
                    n_state = r_neg ? sitda_pkg::ST_SIGN : sitda_pkg::ST_EMIT;
                end
            end
            sitda_pkg::ST_SIGN: begin
                if (w_oload) begin
                    n_ovalid = 1'b1;
                    n_ch     = sitda_pkg::ChMinus;
                    n_last   = 1'b0;
                    n_state  = sitda_pkg::ST_EMIT;
                end
            end
            sitda_pkg::ST_EMIT: begin
                if (w_oload) begin
                    n_ovalid    = 1'b1;
                    n_ch        = sitda_pkg::ChZero + {4'd0, w_top};
                    n_last      = (r_left == LeftW'(1));
                    w_ctrl.move = 1'b1;
                    n_left      = r_left - 1'b1;
                    if (r_left == LeftW'(1)) begin
                        n_state = sitda_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = sitda_pkg::ST_IDLE;
            end
        endcase
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sitda_pkg::ST_CONV) |-> !w_ovf)
        else $error("digit row overflow during conversion");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sitda_pkg::ST_EMIT) |-> (w_top <= sitda_pkg::DigitMax))
        else $error("non-decimal digit at top of row");

    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sitda_pkg::ST_SKIP || r_state == sitda_pkg::ST_EMIT) |-> (r_left != '0))
        else $error("digit count ran out");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (o_stall && r_state == sitda_pkg::ST_CONV))
        else $error("request accepted without starting conversion");

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int Width         = sitda_pkg::DefaultValueWidth;
    localparam int Radix         = 10;
    localparam int MaxDigits     = 20;
    localparam int ResetCycles   = 8;
    localparam int IdlePercent   = 18;
    localparam int HoldCycles    = 300;
    localparam int DrainCycles   = 60;
    // no-handshake limit: the hold-off plus one full conversion, taken several times over
    localparam int WatchdogLimit = 3000;
    localparam int MaxReports    = 10;
    localparam int NumCorners    = 22;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_char;

    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic signed [Width-1:0] i_value = '0;
    logic                    i_stall = 1'b0;
    logic                    o_stall;
    logic                    o_valid;
    logic [7:0]              o_ch;
    logic                    o_last;

    t_char expected_text[$];
    int    mismatches    = 0;
    int    quiet_cycles  = 0;
    bit    idle_on       = 1'b1;
    int    hold_requests = 0;
    int    holds_served  = 0;
    int    hold_left     = 0;

    signed_int_to_decimal_ascii #(
        .VALUE_WIDTH(Width)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_value(i_value),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_ch   (o_ch),
        .o_last (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Expected decimal text of one value: sign first, then digits, most significant first
    function automatic void predict_text(input logic [Width-1:0] value);
        logic [Width-1:0] magnitude;
        logic [3:0]       digits [MaxDigits];
        int               count;
        t_char            c;
        magnitude = value[Width-1] ? (~value + 1'b1) : value;
        count = 0;
        do begin
            digits[count] = 4'(magnitude % Radix);
            magnitude = magnitude / Radix;
            count++;
        end while (magnitude != 0);
        if (value[Width-1]) begin
            c.ch = sitda_pkg::ChMinus;
            c.last = 1'b0;
            expected_text.push_back(c);
        end
        for (int i = count - 1; i >= 0; i--) begin
            c.ch = sitda_pkg::ChZero + digits[i];
            c.last = (i == 0);
            expected_text.push_back(c);
        end
    endfunction

    // Spread values over every text length, both signs and the ends of the range
    function automatic logic signed [Width-1:0] random_value();
        int unsigned      pick;
        int unsigned      limit;
        logic [Width-1:0] v;
        pick = $urandom_range(3);
        limit = 1;
        case (pick)
            0: v = $urandom;
            1: begin
                repeat ($urandom_range(1, 9)) limit *= Radix;
                v = $urandom_range(limit - 1, 0);
            end
            2: v = $urandom_range(99);
            default: v = {1'b0, {(Width-1){1'b1}}} - $urandom_range(15);
        endcase
        if ($urandom_range(1)) v = -v;
        return v;
    endfunction

    task automatic send_value(input logic signed [Width-1:0] value);
        while (idle_on && ($urandom_range(99) < IdlePercent)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        predict_text(value);
    endtask

    task automatic report_mismatch(input string what, input t_char want, input t_char got);
        mismatches++;
        if (mismatches <= MaxReports)
            $display("%0t: %s: expected ch=%0d last=%b, got ch=%0d last=%b",
                     $time, what, want.ch, want.last, got.ch, got.last);
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested
    always @(posedge i_clk) begin
        if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left = HoldCycles;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= idle_on && ($urandom_range(99) < IdlePercent);
        end
    end

    always @(posedge i_clk) begin : check_chars
        t_char want;
        t_char got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.ch = o_ch;
            got.last = o_last;
            if (expected_text.size() == 0) begin
                want.ch = 'x;
                want.last = 1'bx;
                report_mismatch("character with no request pending", want, got);
            end else begin
                want = expected_text.pop_front();
                if (got.ch !== want.ch || got.last !== want.last)
                    report_mismatch("character mismatch", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WatchdogLimit) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic test_corner_values;
        logic signed [Width-1:0] corners [NumCorners] = '{
            32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
            32'sd99, 32'sd100, 32'sd101, 32'sd999999999, 32'sd1000000000,
            -32'sd1000000000, 32'sd1000000009, 32'sd1234567890, -32'sd123456789,
            32'sd2147483647, -32'sd2147483647, 32'h8000_0000, 32'h8000_0001,
            32'h5555_5555, 32'hAAAA_AAAA
        };
        idle_on = 1'b1;
        foreach (corners[i]) send_value(corners[i]);
    endtask

    task automatic test_random_with_gaps;
        idle_on = 1'b1;
        repeat (200) send_value(random_value());
    endtask

    task automatic test_back_to_back;
        idle_on = 1'b0;
        repeat (80) send_value(random_value());
    endtask

    // Hold the output long enough for the block to fill and stall its input
    task automatic test_output_hold_off;
        idle_on = 1'b0;
        hold_requests++;
        repeat (30) send_value(random_value());
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_values;
        test_random_with_gaps;
        test_back_to_back;
        test_output_hold_off;
        i_valid <= 1'b0;
        while (expected_text.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0 && expected_text.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
